/* src/kfac_pkg.sv */
// ----------------------------------------------------------------------------
// kfac_pkg
// Shared types and codes for the keyed feature answer cache.
// ----------------------------------------------------------------------------
package kfac_pkg;

  localparam int SLOTS_DEF       = 16;
  localparam int MAX_PAYLOAD_DEF = 64;

  // request codes
  localparam logic [1:0] REQ_SET_HDR  = 2'd0;
  localparam logic [1:0] REQ_SET_DATA = 2'd1;
  localparam logic [1:0] REQ_GET      = 2'd2;

  // result status codes
  localparam logic [2:0] STS_ACK     = 3'd0;
  localparam logic [2:0] STS_BAD_LEN = 3'd1;
  localparam logic [2:0] STS_TOO_BIG = 3'd2;
  localparam logic [2:0] STS_DATA    = 3'd3;
  localparam logic [2:0] STS_STALL   = 3'd4;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [7:0]  seq;
    logic [7:0]  key_id;
    logic [15:0] frame_len;
    logic [15:0] req_len;
    logic [7:0]  data_byte;
  } kfac_req_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] echo_seq;
    logic [7:0] out_byte;
    logic [6:0] out_count;
    logic       last;
  } kfac_rsp_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_READ,
    ST_SEND
  } kfac_state_t;

endpackage

/* src/keyed_feature_answer_cache.sv */
// ----------------------------------------------------------------------------
// keyed_feature_answer_cache
// Report answer cache: set header / set data / get over a slot table and a
// payload byte memory.
//
//   channel | dir | handshake             | payload
//   --------+-----+-----------------------+----------------------
//   req     | in  | req_valid / req_ready | req_data (kfac_req_t)
//   rsp     | out | rsp_valid / rsp_ready | rsp_data (kfac_rsp_t)
//
// One item at a time. Set header, set data and a get that stalls: take the
// item (slot compares registered), then execute. A get that hits then does
// one payload memory read and one result register load per byte.
// Reset clears the slot table; unwritten payload bytes read as zero through
// per-slot watermarks. A full result register holds a set header or a
// stalling get in execute, and a get that hits in send, until taken.
// ----------------------------------------------------------------------------
module keyed_feature_answer_cache #(
  parameter int SLOTS       = kfac_pkg::SLOTS_DEF,
  parameter int MAX_PAYLOAD = kfac_pkg::MAX_PAYLOAD_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_ready,
  input  kfac_pkg::kfac_req_t req_data,
  output logic                rsp_valid,
  input  logic                rsp_ready,
  output kfac_pkg::kfac_rsp_t rsp_data
);

  import kfac_pkg::*;

  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int LEN_W  = $clog2(MAX_PAYLOAD + 1);
  localparam int DEPTH  = SLOTS * MAX_PAYLOAD;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  kfac_state_t state, state_next;
  kfac_req_t   req_q;

  logic [SLOT_W-1:0] fill_slot;
  logic [LEN_W-1:0]  fill_pos;
  logic              fill_active;

  logic [SLOT_W-1:0] g_slot;
  logic [LEN_W-1:0]  g_cnt, g_wm, g_pos;

  // tag interface
  logic              cmp_en, tag_wr, wm_en;
  logic [SLOT_W-1:0] rd_idx, set_slot, get_slot;
  logic [LEN_W-1:0]  rd_len, rd_wm, plen;
  logic              get_hit;

  // memory interface
  logic              mem_we, mem_re;
  logic [ADDR_W-1:0] mem_waddr, mem_raddr;
  logic [7:0]        mem_rdata;

  logic              rsp_free, rsp_load;
  kfac_rsp_t         rsp_next;

  logic              len_zero, too_big, data_ok, get_ok, g_last;
  logic [LEN_W-1:0]  get_n;

  assign rsp_free = !rsp_valid || rsp_ready;
  assign len_zero = (req_q.frame_len == 16'd0);
  assign too_big  = (req_q.frame_len > 16'(MAX_PAYLOAD + 1));
  assign plen     = LEN_W'(req_q.frame_len - 16'd1);
  assign rd_idx   = (req_q.req_type == REQ_GET) ? get_slot : fill_slot;
  assign data_ok  = fill_active && (fill_pos < rd_len);
  assign get_n    = (16'(rd_len) > req_q.req_len) ? LEN_W'(req_q.req_len) : rd_len;
  assign get_ok   = get_hit && (get_n != '0);
  assign g_last   = (LEN_W'(g_pos + 1'b1) == g_cnt);

  assign mem_waddr = ADDR_W'(fill_slot) * ADDR_W'(MAX_PAYLOAD) + ADDR_W'(fill_pos);
  assign mem_raddr = ADDR_W'(g_slot) * ADDR_W'(MAX_PAYLOAD) + ADDR_W'(g_pos);

  kfac_tags #(
    .SLOTS       (SLOTS),
    .MAX_PAYLOAD (MAX_PAYLOAD)
  ) u_tags (
    .clk      (clk),
    .rst      (rst),
    .cmp_en   (cmp_en),
    .cmp_id   (req_data.key_id),
    .wr_en    (tag_wr),
    .wr_slot  (set_slot),
    .wr_id    (req_q.key_id),
    .wr_len   (plen),
    .wm_en    (wm_en),
    .wm_val   (LEN_W'(fill_pos + 1'b1)),
    .rd_idx   (rd_idx),
    .rd_len   (rd_len),
    .rd_wm    (rd_wm),
    .set_slot (set_slot),
    .get_hit  (get_hit),
    .get_slot (get_slot)
  );

  kfac_payload_ram #(
    .DEPTH  (DEPTH),
    .ADDR_W (ADDR_W)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (req_q.data_byte),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (req_valid) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        unique case (req_q.req_type)
          REQ_SET_HDR:  state_next = rsp_free ? ST_IDLE : ST_EXEC;
          REQ_SET_DATA: state_next = ST_IDLE;
          REQ_GET: begin
            if (get_ok) begin
              state_next = ST_READ;
            end else begin
              state_next = rsp_free ? ST_IDLE : ST_EXEC;
            end
          end
          default:      state_next = ST_IDLE;
        endcase
      end
      ST_READ: state_next = ST_SEND;
      ST_SEND: begin
        if (rsp_free) begin
          state_next = g_last ? ST_IDLE : ST_READ;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    req_ready = 1'b0;
    cmp_en    = 1'b0;
    tag_wr    = 1'b0;
    wm_en     = 1'b0;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    rsp_load  = 1'b0;
    rsp_next  = '0;
    rsp_next.last = 1'b1;
    unique case (state)
      ST_IDLE: begin
        req_ready = 1'b1;
        cmp_en    = req_valid;
      end
      ST_EXEC: begin
        unique case (req_q.req_type)
          REQ_SET_HDR: begin
            rsp_load          = rsp_free;
            tag_wr            = rsp_free && !len_zero && !too_big;
            rsp_next.echo_seq = req_q.seq;
            if (len_zero) begin
              rsp_next.status = STS_BAD_LEN;
            end else if (too_big) begin
              rsp_next.status = STS_TOO_BIG;
            end else begin
              rsp_next.status = STS_ACK;
            end
          end
          REQ_SET_DATA: begin
            mem_we = data_ok;
            wm_en  = data_ok && (fill_pos == rd_wm);
          end
          REQ_GET: begin
            rsp_load        = rsp_free && !get_ok;
            rsp_next.status = STS_STALL;
          end
          default: ;
        endcase
      end
      ST_READ: mem_re = 1'b1;
      ST_SEND: begin
        rsp_load           = rsp_free;
        rsp_next.status    = STS_DATA;
        rsp_next.out_byte  = (g_pos < g_wm) ? mem_rdata : 8'd0;
        rsp_next.out_count = 7'(g_cnt);
        rsp_next.last      = g_last;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      fill_slot   <= '0;
      fill_pos    <= '0;
      fill_active <= 1'b0;
      g_pos       <= '0;
      rsp_valid   <= 1'b0;
    end else begin
      state <= state_next;
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      if (state == ST_EXEC) begin
        unique case (req_q.req_type)
          REQ_SET_HDR: begin
            if (rsp_free) begin
              if (len_zero || too_big) begin
                fill_active <= 1'b0;
              end else begin
                fill_slot   <= set_slot;
                fill_pos    <= '0;
                fill_active <= (plen != '0);
              end
            end
          end
          REQ_SET_DATA: begin
            if (data_ok) begin
              fill_pos <= LEN_W'(fill_pos + 1'b1);
              if (LEN_W'(fill_pos + 1'b1) >= rd_len) begin
                fill_active <= 1'b0;
              end
            end else begin
              fill_active <= 1'b0;
            end
          end
          REQ_GET: begin
            if (get_ok) begin
              g_pos <= '0;
            end
          end
          default: ;
        endcase
      end
      if (state == ST_SEND && rsp_load) begin
        g_pos <= LEN_W'(g_pos + 1'b1);
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      req_q <= req_data;
    end
    if (state == ST_EXEC && req_q.req_type == REQ_GET && get_ok) begin
      g_slot <= get_slot;
      g_cnt  <= get_n;
      g_wm   <= rd_wm;
    end
    if (rsp_load) begin
      rsp_data <= rsp_next;
    end
  end

endmodule

/* src/kfac_payload_ram.sv */
// ----------------------------------------------------------------------------
// kfac_payload_ram
// Payload byte store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module kfac_payload_ram #(
  parameter int DEPTH  = 1024,
  parameter int ADDR_W = 10
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [7:0]        wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [7:0]        rdata
);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

/* src/kfac_tags.sv */
// ----------------------------------------------------------------------------
// kfac_tags
// Slot id, length and fill watermark registers with the slot lookup.
// ----------------------------------------------------------------------------
module kfac_tags #(
  parameter int SLOTS       = 16,
  parameter int MAX_PAYLOAD = 64
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     cmp_en,
  input  logic [7:0]                               cmp_id,
  input  logic                                     wr_en,
  input  logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] wr_slot,
  input  logic [7:0]                               wr_id,
  input  logic [$clog2(MAX_PAYLOAD + 1)-1:0]       wr_len,
  input  logic                                     wm_en,
  input  logic [$clog2(MAX_PAYLOAD + 1)-1:0]       wm_val,
  input  logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] rd_idx,
  output logic [$clog2(MAX_PAYLOAD + 1)-1:0]       rd_len,
  output logic [$clog2(MAX_PAYLOAD + 1)-1:0]       rd_wm,
  output logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] set_slot,
  output logic                                     get_hit,
  output logic [((SLOTS > 1) ? $clog2(SLOTS) : 1)-1:0] get_slot
);

  import kfac_pkg::*;

  localparam int SLOT_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int LEN_W  = $clog2(MAX_PAYLOAD + 1);

  logic [7:0]       slot_id  [SLOTS];
  logic [LEN_W-1:0] slot_len [SLOTS];
  // bytes below the watermark were written since reset; the rest read as zero
  logic [LEN_W-1:0] slot_wm  [SLOTS];

  // compare results, registered when the item is taken
  logic [SLOTS-1:0] eq_vec, free_vec, live_vec;
  logic [SLOTS-1:0] eq_vec_next, free_vec_next, live_vec_next;

  logic              eq_hit, free_hit;
  logic [SLOT_W-1:0] eq_idx, free_idx;

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      eq_vec_next[i]   = (slot_id[i] == cmp_id);
      free_vec_next[i] = (slot_id[i] == 8'd0) && (slot_len[i] == '0);
      live_vec_next[i] = (slot_id[i] == cmp_id) && (slot_len[i] != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < SLOTS; i++) begin
        slot_id[i]  <= '0;
        slot_len[i] <= '0;
        slot_wm[i]  <= '0;
      end
      eq_vec   <= '0;
      free_vec <= '0;
      live_vec <= '0;
    end else begin
      if (wr_en) begin
        slot_id[wr_slot]  <= wr_id;
        slot_len[wr_slot] <= wr_len;
      end
      if (wm_en) begin
        slot_wm[rd_idx] <= wm_val;
      end
      if (cmp_en) begin
        eq_vec   <= eq_vec_next;
        free_vec <= free_vec_next;
        live_vec <= live_vec_next;
      end
    end
  end

  // first-set search, lowest index wins
  always_comb begin
    eq_hit   = 1'b0;
    eq_idx   = '0;
    free_hit = 1'b0;
    free_idx = '0;
    get_hit  = 1'b0;
    get_slot = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (eq_vec[i]) begin
        eq_hit = 1'b1;
        eq_idx = SLOT_W'(i);
      end
      if (free_vec[i]) begin
        free_hit = 1'b1;
        free_idx = SLOT_W'(i);
      end
      if (live_vec[i]) begin
        get_hit  = 1'b1;
        get_slot = SLOT_W'(i);
      end
    end
  end

  assign set_slot = eq_hit ? eq_idx : (free_hit ? free_idx : '0);
  assign rd_len   = slot_len[rd_idx];
  assign rd_wm    = slot_wm[rd_idx];

endmodule
